### design/stef_pkg.sv
// ---------------------------------------------------------------------------
// stef_pkg
// Shared widths, table entry layout and the request/response words between
// the edge control and the union-find forest.
// ---------------------------------------------------------------------------
package stef_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int COUNT_W      = VIDX_W + 1;
  // Generation tag kept with every table entry; a stale tag reads as a root.
  localparam int EPOCH_W      = 4;

  typedef logic [VIDX_W-1:0]  vidx_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [EPOCH_W-1:0] epoch_t;

  typedef struct packed {
    epoch_t epoch;
    logic   root;
    vidx_t  parent;
  } entry_t;

  typedef struct packed {
    logic  start;
    logic  clear;
    logic  run;
    vidx_t a;
    vidx_t b;
  } fst_req_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic joined;
  } fst_resp_t;

endpackage

### design/stef_if.sv
// ---------------------------------------------------------------------------
// stef_in_if / stef_out_if
// Valid/ready channels for edge words in and result words out.
// ---------------------------------------------------------------------------
interface stef_in_if import stef_pkg::*; ();
  logic  valid;
  logic  ready;
  vidx_t edge_from;
  vidx_t edge_to;
  logic  new_graph;

  modport source (output valid, output edge_from, output edge_to, output new_graph,
                  input ready);
  modport sink   (input valid, input edge_from, input edge_to, input new_graph,
                  output ready);
endinterface

interface stef_out_if import stef_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  taken;
  vidx_t tree_edges;
  logic  tree_complete;

  modport source (output valid, output taken, output tree_edges, output tree_complete,
                  input ready);
  modport sink   (input valid, input taken, input tree_edges, input tree_complete,
                  output ready);
endinterface

### design/stef_forest.sv
// ---------------------------------------------------------------------------
// stef_forest
// Parent table in a synchronous RAM plus the sequencer that walks both root
// chains, compresses them, and links the first root under the second.
// ---------------------------------------------------------------------------
module stef_forest import stef_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  fst_req_t  req,
  output fst_resp_t resp
);

  localparam logic [2:0] F_CLEAR  = 3'd0;
  localparam logic [2:0] F_IDLE   = 3'd1;
  localparam logic [2:0] F_WALK_A = 3'd2;
  localparam logic [2:0] F_COMP_A = 3'd3;
  localparam logic [2:0] F_WALK_B = 3'd4;
  localparam logic [2:0] F_COMP_B = 3'd5;
  localparam logic [2:0] F_REPLY  = 3'd6;
  localparam logic [2:0] F_LOAD_A = 3'd7;

  entry_t parent_mem_r [MAX_VERTICES];
  entry_t rd_data_r;

  logic [2:0] state_r, state_nxt;
  epoch_t     epoch_r, epoch_nxt;
  vidx_t      clr_idx_r, clr_idx_nxt;
  logic       pend_r, pend_nxt;
  logic       run_r, run_nxt;
  logic       joined_r, joined_nxt;
  vidx_t      a_r, a_nxt, b_r, b_nxt;
  vidx_t      ra_r, ra_nxt, rb_r, rb_nxt;
  vidx_t      cur_r, cur_nxt;

  logic   we;
  vidx_t  wa;
  entry_t wd;
  vidx_t  rd_addr;
  logic   cur_root;

  // A tag from an older generation means the entry was cleared since.
  assign cur_root = (rd_data_r.epoch != epoch_r) || rd_data_r.root;

  always_comb begin
    state_nxt   = state_r;
    epoch_nxt   = epoch_r;
    clr_idx_nxt = clr_idx_r;
    pend_nxt    = pend_r;
    run_nxt     = run_r;
    joined_nxt  = joined_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    ra_nxt      = ra_r;
    rb_nxt      = rb_r;
    cur_nxt     = cur_r;
    we          = 1'b0;
    wa          = cur_r;
    wd          = '{epoch: epoch_r, root: 1'b0, parent: ra_r};
    rd_addr     = cur_r;

    case (state_r)
      F_CLEAR: begin
        we = 1'b1;
        wa = clr_idx_r;
        wd = '{epoch: epoch_r, root: 1'b1, parent: '0};
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == vidx_t'(MAX_VERTICES - 1)) begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = F_IDLE;
          end else if (run_r) begin
            // clear of the last entry lands at this edge, so the first
            // endpoint is read in the cycle after, from F_LOAD_A
            state_nxt = F_LOAD_A;
          end else begin
            joined_nxt = 1'b0;
            state_nxt  = F_REPLY;
          end
        end
      end
      F_LOAD_A: begin
        rd_addr   = a_r;
        cur_nxt   = a_r;
        state_nxt = F_WALK_A;
      end
      F_IDLE: begin
        if (req.start) begin
          a_nxt      = req.a;
          b_nxt      = req.b;
          run_nxt    = req.run;
          joined_nxt = 1'b0;
          if (req.clear && (epoch_r == '1)) begin
            epoch_nxt   = '0;
            clr_idx_nxt = '0;
            pend_nxt    = 1'b1;
            state_nxt   = F_CLEAR;
          end else begin
            if (req.clear) begin
              epoch_nxt = epoch_r + 1'b1;
            end
            if (req.run) begin
              rd_addr   = req.a;
              cur_nxt   = req.a;
              state_nxt = F_WALK_A;
            end else begin
              state_nxt = F_REPLY;
            end
          end
        end
      end
      F_WALK_A: begin
        if (cur_root) begin
          ra_nxt    = cur_r;
          rd_addr   = a_r;
          cur_nxt   = a_r;
          state_nxt = F_COMP_A;
        end else begin
          rd_addr = rd_data_r.parent;
          cur_nxt = rd_data_r.parent;
        end
      end
      F_COMP_A: begin
        if ((cur_r != ra_r) && !cur_root) begin
          we      = 1'b1;
          wa      = cur_r;
          wd      = '{epoch: epoch_r, root: 1'b0, parent: ra_r};
          rd_addr = rd_data_r.parent;
          cur_nxt = rd_data_r.parent;
        end else begin
          // no write this cycle, so the next read cannot meet a write
          rd_addr   = b_r;
          cur_nxt   = b_r;
          state_nxt = F_WALK_B;
        end
      end
      F_WALK_B: begin
        if (cur_root) begin
          rb_nxt    = cur_r;
          rd_addr   = b_r;
          cur_nxt   = b_r;
          state_nxt = F_COMP_B;
        end else begin
          rd_addr = rd_data_r.parent;
          cur_nxt = rd_data_r.parent;
        end
      end
      F_COMP_B: begin
        if ((cur_r != rb_r) && !cur_root) begin
          we      = 1'b1;
          wa      = cur_r;
          wd      = '{epoch: epoch_r, root: 1'b0, parent: rb_r};
          rd_addr = rd_data_r.parent;
          cur_nxt = rd_data_r.parent;
        end else begin
          if (ra_r != rb_r) begin
            we         = 1'b1;
            wa         = ra_r;
            wd         = '{epoch: epoch_r, root: 1'b0, parent: rb_r};
            joined_nxt = 1'b1;
          end
          state_nxt = F_REPLY;
        end
      end
      F_REPLY: begin
        state_nxt = F_IDLE;
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  // Chain walks never read and write one entry at the same edge: a node and
  // its parent differ, and every phase change is a cycle without a write.
  always_ff @(posedge clk) begin
    if (we) begin
      parent_mem_r[wa] <= wd;
    end
    rd_data_r <= parent_mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_CLEAR;
      epoch_r   <= '0;
      clr_idx_r <= '0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      epoch_r   <= epoch_nxt;
      clr_idx_r <= clr_idx_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_r    <= run_nxt;
    joined_r <= joined_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    ra_r     <= ra_nxt;
    rb_r     <= rb_nxt;
    cur_r    <= cur_nxt;
  end

  assign resp.idle   = (state_r == F_IDLE);
  assign resp.done   = (state_r == F_REPLY);
  assign resp.joined = joined_r;

endmodule

### design/spanning_tree_edge_filter.sv
// ---------------------------------------------------------------------------
// spanning_tree_edge_filter
// Kruskal edge filter: keeps an edge when it joins two union-find trees.
// ---------------------------------------------------------------------------
// Edges must arrive in ascending cost order; one result word per edge word.
// One edge is handled at a time. For a considered edge, each find walks its
// endpoint's chain through the parent RAM (one read per hop plus one for the
// root) and then walks it again writing the compressed links, one entry per
// cycle. An edge that is not considered (tree complete or endpoint out of
// range) goes to its result with no finds. After reset, and on every
// sixteenth new_graph word, a clearing pass rewrites all 1024 table entries,
// one per cycle, before the edge is handled (through F_LOAD_A when the edge
// is considered); other graph restarts are free. A result word that cannot
// leave is parked and holds off the next edge until it moves out. The user
// must write vertex_count only while the block is idle; the block itself
// does not enforce it.
// ---------------------------------------------------------------------------
module spanning_tree_edge_filter import stef_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  stef_in_if.sink    in_ch,
  stef_out_if.source out_ch,
  input  logic       cfg_we,
  input  count_t     cfg_wdata
);

  fst_req_t  req;
  fst_resp_t resp;

  count_t vc_r;
  count_t vc_dec;
  vidx_t  nm1;
  vidx_t  kept_r;
  vidx_t  kept_base;
  vidx_t  kept_sum;
  logic   busy_r;
  logic   accept;
  logic   out_free;

  logic  out_valid_r;
  logic  out_taken_r;
  vidx_t out_edges_r;
  logic  out_done_r;

  logic  hold_valid_r;
  logic  hold_taken_r;
  vidx_t hold_edges_r;
  logic  hold_done_r;

  stef_forest u_forest (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .resp (resp)
  );

  // effective count minus one, count clamped to 1..MAX_VERTICES
  assign vc_dec = vc_r - count_t'(1);
  always_comb begin
    if (vc_r == '0) begin
      nm1 = '0;
    end else if (vc_r > count_t'(MAX_VERTICES)) begin
      nm1 = vidx_t'(MAX_VERTICES - 1);
    end else begin
      nm1 = vc_dec[VIDX_W-1:0];
    end
  end

  assign in_ch.ready = !busy_r && resp.idle;
  assign accept      = in_ch.valid && in_ch.ready;
  assign kept_base   = in_ch.new_graph ? '0 : kept_r;
  assign kept_sum    = kept_r + vidx_t'(resp.joined);
  assign out_free    = !out_valid_r || out_ch.ready;

  assign req.start = accept;
  assign req.clear = in_ch.new_graph;
  assign req.run   = (kept_base < nm1) && (in_ch.edge_from <= nm1) && (in_ch.edge_to <= nm1);
  assign req.a     = in_ch.edge_from;
  assign req.b     = in_ch.edge_to;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= count_t'(MAX_VERTICES);
    end else if (cfg_we) begin
      vc_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      kept_r       <= '0;
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
        kept_r <= kept_base;
      end
      if (resp.done) begin
        kept_r <= kept_sum;
        if (out_free) begin
          out_valid_r <= 1'b1;
          busy_r      <= 1'b0;
        end else begin
          hold_valid_r <= 1'b1;
        end
      end else if (hold_valid_r && out_free) begin
        out_valid_r  <= 1'b1;
        hold_valid_r <= 1'b0;
        busy_r       <= 1'b0;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (resp.done) begin
      if (out_free) begin
        out_taken_r <= resp.joined;
        out_edges_r <= kept_sum;
        out_done_r  <= (kept_sum >= nm1);
      end else begin
        hold_taken_r <= resp.joined;
        hold_edges_r <= kept_sum;
        hold_done_r  <= (kept_sum >= nm1);
      end
    end else if (hold_valid_r && out_free) begin
      out_taken_r <= hold_taken_r;
      out_edges_r <= hold_edges_r;
      out_done_r  <= hold_done_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.taken         = out_taken_r;
  assign out_ch.tree_edges    = out_edges_r;
  assign out_ch.tree_complete = out_done_r;

endmodule

### bench/spanning_tree_edge_filter_tb.sv
// ---------------------------------------------------------------------------
// spanning_tree_edge_filter_tb
// Self-checking bench for the Kruskal edge filter. A short table of edge
// and register rows is walked first, then randomised graphs with random
// vertex counts. Every result word is checked against a typed expected word
// or a union-find model kept in the bench, under several idling and back-pressure patterns.
// ---------------------------------------------------------------------------
module spanning_tree_edge_filter_tb;
  import stef_pkg::*;

  localparam int QUIET_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_EDGES = 1700;
  localparam int INDEX_SPACE  = 1024;
  localparam int N_ROWS       = 28;
  localparam logic [VIDX_W:0] ROOT_MARK = {1'b1, {VIDX_W{1'b0}}};

  typedef struct packed {
    logic  taken;
    vidx_t tree_edges;
    logic  tree_complete;
  } result_t;

  typedef enum logic {ROW_EDGE, ROW_CFG} row_kind_t;
  typedef enum logic {WANT_MODEL, WANT_TYPED} row_check_t;

  typedef struct packed {
    row_kind_t  kind;
    count_t     cfg_val;
    vidx_t      from;
    vidx_t      to;
    logic       ng;
    row_check_t check;
    result_t    want;
  } stim_row_t;

  // kind, vertex count, from, to, new_graph, check, expected word
  stim_row_t directed [N_ROWS] = '{
    '{ROW_EDGE, 11'd0,    10'd0,    10'd1023, 1'b0, WANT_TYPED, '{1'b1, 10'd1, 1'b0}},
    '{ROW_EDGE, 11'd0,    10'd1023, 10'd0,    1'b0, WANT_TYPED, '{1'b0, 10'd1, 1'b0}},
    '{ROW_EDGE, 11'd0,    10'd5,    10'd5,    1'b0, WANT_TYPED, '{1'b0, 10'd1, 1'b0}},
    '{ROW_EDGE, 11'd0,    10'd0,    10'd1,    1'b1, WANT_TYPED, '{1'b1, 10'd1, 1'b0}},
    '{ROW_CFG,  11'd4,    10'd0,    10'd0,    1'b0, WANT_MODEL, '0},
    '{ROW_EDGE, 11'd0,    10'd0,    10'd1,    1'b1, WANT_TYPED, '{1'b1, 10'd1, 1'b0}},
    '{ROW_EDGE, 11'd0,    10'd2,    10'd3,    1'b0, WANT_TYPED, '{1'b1, 10'd2, 1'b0}},
    '{ROW_EDGE, 11'd0,    10'd1,    10'd3,    1'b0, WANT_TYPED, '{1'b1, 10'd3, 1'b1}},
    // tree complete: no finds, not taken
    '{ROW_EDGE, 11'd0,    10'd0,    10'd2,    1'b0, WANT_TYPED, '{1'b0, 10'd3, 1'b1}},
    // endpoint beyond the vertex count
    '{ROW_EDGE, 11'd0,    10'd4,    10'd0,    1'b1, WANT_TYPED, '{1'b0, 10'd0, 1'b0}},
    '{ROW_EDGE, 11'd0,    10'd0,    10'd1023, 1'b0, WANT_TYPED, '{1'b0, 10'd0, 1'b0}},
    // build a chain, then a find that compresses it
    '{ROW_EDGE, 11'd0,    10'd0,    10'd1,    1'b0, WANT_MODEL, '0},
    '{ROW_EDGE, 11'd0,    10'd1,    10'd2,    1'b0, WANT_MODEL, '0},
    '{ROW_EDGE, 11'd0,    10'd0,    10'd2,    1'b0, WANT_MODEL, '0},
    '{ROW_EDGE, 11'd0,    10'd3,    10'd0,    1'b0, WANT_MODEL, '0},
    // zero acts as one vertex: complete with no edges
    '{ROW_CFG,  11'd0,    10'd0,    10'd0,    1'b0, WANT_MODEL, '0},
    '{ROW_EDGE, 11'd0,    10'd0,    10'd0,    1'b1, WANT_TYPED, '{1'b0, 10'd0, 1'b1}},
    // oversized count clamps to the index space
    '{ROW_CFG,  11'd2047, 10'd0,    10'd0,    1'b0, WANT_MODEL, '0},
    '{ROW_EDGE, 11'd0,    10'd1023, 10'd512,  1'b1, WANT_TYPED, '{1'b1, 10'd1, 1'b0}},
    '{ROW_EDGE, 11'd0,    10'd682,  10'd341,  1'b0, WANT_TYPED, '{1'b1, 10'd2, 1'b0}},
    // count lowered mid-graph keeps the kept count
    '{ROW_CFG,  11'd2,    10'd0,    10'd0,    1'b0, WANT_MODEL, '0},
    '{ROW_EDGE, 11'd0,    10'd0,    10'd1,    1'b0, WANT_TYPED, '{1'b0, 10'd2, 1'b1}},
    '{ROW_EDGE, 11'd0,    10'd0,    10'd1,    1'b1, WANT_TYPED, '{1'b1, 10'd1, 1'b1}},
    '{ROW_CFG,  11'd1024, 10'd0,    10'd0,    1'b0, WANT_MODEL, '0},
    '{ROW_EDGE, 11'd0,    10'd0,    10'd1,    1'b0, WANT_MODEL, '0},
    '{ROW_EDGE, 11'd0,    10'd1022, 10'd1023, 1'b0, WANT_MODEL, '0},
    '{ROW_CFG,  11'd1,    10'd0,    10'd0,    1'b0, WANT_MODEL, '0},
    '{ROW_EDGE, 11'd0,    10'd1023, 10'd1023, 1'b1, WANT_TYPED, '{1'b0, 10'd0, 1'b1}}
  };

  logic   clk = 1'b0;
  logic   rst_n;
  logic   cfg_we;
  count_t cfg_wdata;

  stef_in_if  in_ch ();
  stef_out_if out_ch ();

  spanning_tree_edge_filter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Bench copy of the forest: top bit marks a root, low bits hold the parent.
  logic [VIDX_W:0] forest [MAX_VERTICES];
  vidx_t           kept_edges;
  count_t          vcount;

  result_t expected_results [$];
  int      errors   = 0;
  int      n_sent   = 0;
  int      send_pct = 0;
  int      recv_pct = 0;
  bit      hold_req = 1'b0;

  function automatic void clear_forest();
    for (int i = 0; i < MAX_VERTICES; i++) forest[vidx_t'(i)] = ROOT_MARK;
    kept_edges = '0;
  endfunction

  function automatic int unsigned eff_count();
    int unsigned n;
    int unsigned lim;
    n   = 32'(vcount);
    lim = (MAX_VERTICES < INDEX_SPACE) ? MAX_VERTICES : INDEX_SPACE;
    if (n < 1) n = 1;
    if (n > lim) n = lim;
    return n;
  endfunction

  function automatic int unsigned find_root_compress(int unsigned v);
    int unsigned r;
    int unsigned cur;
    int unsigned nxt;
    int unsigned steps;
    r     = v;
    steps = 0;
    while (!forest[vidx_t'(r)][VIDX_W] && steps < MAX_VERTICES) begin
      nxt = 32'(forest[vidx_t'(r)][VIDX_W-1:0]);
      if (nxt >= MAX_VERTICES) break;
      r = nxt;
      steps++;
    end
    // second walk points every node on the path straight at the root
    cur   = v;
    steps = 0;
    while (cur != r && !forest[vidx_t'(cur)][VIDX_W] && steps < MAX_VERTICES) begin
      nxt                  = 32'(forest[vidx_t'(cur)][VIDX_W-1:0]);
      forest[vidx_t'(cur)] = {1'b0, vidx_t'(r)};
      if (nxt >= MAX_VERTICES) break;
      cur = nxt;
      steps++;
    end
    return r;
  endfunction

  function automatic result_t filter_edge(vidx_t a, vidx_t b, logic ng);
    int unsigned n;
    int unsigned ra;
    int unsigned rb;
    result_t     res;
    if (ng) clear_forest();
    n         = eff_count();
    res.taken = 1'b0;
    if (kept_edges < n - 1 && a < n && b < n) begin
      ra = find_root_compress(32'(a));
      rb = find_root_compress(32'(b));
      if (ra != rb) begin
        forest[vidx_t'(ra)] = {1'b0, vidx_t'(rb)};
        kept_edges          = kept_edges + 1'b1;
        res.taken           = 1'b1;
      end
    end
    res.tree_edges    = kept_edges;
    res.tree_complete = (kept_edges >= n - 1);
    return res;
  endfunction

  // Call at a rising edge; returns at the edge where the word is accepted.
  task automatic send_edge(vidx_t a, vidx_t b, logic ng, logic typed, result_t want);
    result_t model;
    while (send_pct > 0 && $urandom_range(99) < send_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.edge_from <= a;
    in_ch.edge_to   <= b;
    in_ch.new_graph <= ng;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    model = filter_edge(a, b, ng);
    expected_results.push_back(typed ? want : model);
    n_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_vertex_count(count_t v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    vcount = v;
  endtask

  initial begin : result_sink
    int      hold_left;
    result_t got;
    result_t want;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = '{out_ch.taken, out_ch.tree_edges, out_ch.tree_complete};
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result word with none expected, got taken=%0d edges=%0d complete=%0d",
                   $time, got.taken, got.tree_edges, got.tree_complete);
        end else begin
          want = expected_results.pop_front();
          if (got.taken !== want.taken || got.tree_edges !== want.tree_edges ||
              got.tree_complete !== want.tree_complete) begin
            errors++;
            $display("%0t: mismatch, expected taken=%0d edges=%0d complete=%0d, %s",
                     $time, want.taken, want.tree_edges, want.tree_complete,
                     $sformatf("got taken=%0d edges=%0d complete=%0d",
                               got.taken, got.tree_edges, got.tree_complete));
          end
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int          seg;
    int          target;
    int          n_items;
    count_t      new_count;
    vidx_t       a;
    vidx_t       b;
    logic        ng;
    bit          restart;
    int unsigned n;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.edge_from = '0;
    in_ch.edge_to   = '0;
    in_ch.new_graph = 1'b0;
    vcount          = 11'd1024;
    clear_forest();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG)
        write_vertex_count(directed[i].cfg_val);
      else
        send_edge(directed[i].from, directed[i].to, directed[i].ng,
                  directed[i].check == WANT_TYPED, directed[i].want);
    end

    seg    = 0;
    target = n_sent + RANDOM_EDGES;
    while (n_sent < target) begin
      case ($urandom_range(7))
        0:       new_count = 11'd1024;
        1:       new_count = count_t'($urandom_range(2047));
        2:       new_count = count_t'($urandom_range(1, 3));
        default: new_count = count_t'($urandom_range(2, 40));
      endcase
      write_vertex_count(new_count);
      case (seg % 4)
        0:       begin send_pct = 0;  recv_pct = 0;  end
        1:       begin send_pct = 62; recv_pct = 0;  end
        2:       begin send_pct = 0;  recv_pct = 62; end
        default: begin send_pct = 38; recv_pct = 38; end
      endcase
      // long hold on the result side while edges keep coming
      if (seg % 10 == 3) hold_req = 1'b1;
      n_items = $urandom_range(40, 120);
      // now and then carry the old graph over a count change
      restart = ($urandom_range(3) != 0);
      repeat (n_items) begin
        n = eff_count();
        if (restart)
          ng = 1'b1;
        else
          ng = ($urandom_range(24) == 0) ||
               (kept_edges >= n - 1 && $urandom_range(1) == 0);
        restart = 1'b0;
        if ($urandom_range(9) == 0) begin
          a = vidx_t'($urandom_range(1023));
          b = vidx_t'($urandom_range(1023));
        end else begin
          a = vidx_t'($urandom_range(n - 1));
          b = vidx_t'($urandom_range(n - 1));
        end
        send_edge(a, b, ng, 1'b0, '0);
      end
      seg++;
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

### filelist.f
design/stef_pkg.sv
design/stef_if.sv
design/stef_forest.sv
design/spanning_tree_edge_filter.sv
bench/spanning_tree_edge_filter_tb.sv
